@@ rtl/core/crc_checked_frame_receiver_core_macros.svh @@
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CCFR_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");
`define CCFR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");
`else
`define CCFR_ASSERT_IMPL(name, ante, cons)
`define CCFR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/core/ccfr_pkg.sv @@
// Types and constants of the CRC-checked frame receiver.
package ccfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 5;
   localparam int ALEN_W  = 6;
   localparam int CSR_W   = 2;

   // At most this many payload bytes are forwarded per frame.
   localparam logic [5:0] MAX_RESULTS = 6'd32;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] SYNC_FIRST_RST    = 8'hBC;
   localparam logic [7:0] SYNC_SECOND_RST   = 8'h35;
   localparam logic [7:0] ACCEPT_ID_RST     = 8'h01;
   localparam logic [5:0] ACCEPT_LENGTH_RST = 6'd6;

   localparam logic [CSR_W-1:0] CSR_SYNC_FIRST    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SYNC_SECOND   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ACCEPT_ID     = 2'd2;
   localparam logic [CSR_W-1:0] CSR_ACCEPT_LENGTH = 2'd3;

   typedef enum logic [6:0] {
      PH_SYNC1   = 7'b0000001,
      PH_SYNC2   = 7'b0000010,
      PH_LEN     = 7'b0000100,
      PH_ID      = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CRC_LO  = 7'b0100000,
      PH_CRC_HI  = 7'b1000000
   } phase_type;

   typedef enum logic [3:0] {
      CT_IDLE = 4'b0001,
      CT_CRC  = 4'b0010,
      CT_RD   = 4'b0100,
      CT_OUT  = 4'b1000
   } ctrl_type;

endpackage

@@ rtl/core/ccfr_req_if.sv @@
// Received byte channel.
interface ccfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ccfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/ccfr_rsp_if.sv @@
// Payload byte result channel.
interface ccfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ccfr_pkg::BYTE_W-1:0]  data_byte;
   logic [ccfr_pkg::INDEX_W-1:0] byte_index;
   logic                         last;

   modport source (output valid, output data_byte, output byte_index, output last,
                   input ready);
   modport sink (input valid, input data_byte, input byte_index, input last,
                 output ready);
endinterface

@@ rtl/core/ccfr_csr_if.sv @@
// Configuration register write channel.
interface ccfr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ccfr_pkg::CSR_W-1:0]   index;
   logic [ccfr_pkg::BYTE_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/crc_checked_frame_receiver_core.sv @@
// Sync-header frame parser with bit-serial CRC-16/XMODEM check and payload replay.
// Sync, CRC and rejected bytes are taken straight from idle; length, id and payload bytes then
// block input while the CRC register advances one bit per cycle through 8 shift steps.
// An accepted frame of N payload bytes is replayed as min(N, 32) transfers, each a payload
// memory read followed by an output state held until taken, with no input meanwhile.
// Synchronous active-high reset loads the register defaults and waits for the first sync.
`include "crc_checked_frame_receiver_core_macros.svh"

module crc_checked_frame_receiver_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   ccfr_req_if.sink   req_chan,
   ccfr_rsp_if.source rsp_chan,
   ccfr_csr_if.sink   csr_chan
);

   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0]             sync_first_ff;
   logic [7:0]             sync_second_ff;
   logic [7:0]             accept_id_ff;
   logic [5:0]             accept_length_ff;

   ccfr_pkg::phase_type    phase_ff, phase_in;
   ccfr_pkg::ctrl_type     ctrl_ff, ctrl_in;
   logic [LW-1:0]          frame_len_ff, frame_len_in;
   logic [7:0]             frame_id_ff, frame_id_in;
   logic [LW-1:0]          fill_ff, fill_in;
   logic [LW-1:0]          fill_next;
   logic [7:0]             crc_low_ff, crc_low_in;
   logic [15:0]            crc_ff, crc_in;
   logic [15:0]            crc_shift;
   logic [2:0]             bit_cnt_ff, bit_cnt_in;
   logic [4:0]             idx_ff, idx_in;
   logic [5:0]             emit_cnt;
   logic                   frame_ok;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   mem_we;
   logic [7:0]             rd_data_ff;
   logic [7:0]             payload_mem [MAX_PAYLOAD];
   logic [7:0]             rx;

   assign rx       = req_chan.rx_byte;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (ctrl_ff == ccfr_pkg::CT_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = (ctrl_ff == ccfr_pkg::CT_OUT);
   assign rsp_chan.data_byte  = rd_data_ff;
   assign rsp_chan.byte_index = idx_ff;
   assign rsp_chan.last       = ((8'(idx_ff) + 8'd1) == 8'(frame_len_ff));

   // Frames longer than the result limit forward only their first bytes.
   assign emit_cnt = (8'(frame_len_ff) > 8'(ccfr_pkg::MAX_RESULTS)) ?
                     ccfr_pkg::MAX_RESULTS : 6'(frame_len_ff);

   assign frame_ok = ({rx, crc_low_ff} == crc_ff) && (frame_id_ff == accept_id_ff) &&
                     (8'(frame_len_ff) == 8'(accept_length_ff));

   assign fill_next = (9'(fill_ff) < 9'(MAX_PAYLOAD)) ? (fill_ff + LW'(1)) : fill_ff;

   assign crc_shift = crc_ff[15] ? ({crc_ff[14:0], 1'b0} ^ ccfr_pkg::CRC_POLY) :
                                   {crc_ff[14:0], 1'b0};

   always_comb begin
      phase_in     = phase_ff;
      ctrl_in      = ctrl_ff;
      frame_len_in = frame_len_ff;
      frame_id_in  = frame_id_ff;
      fill_in      = fill_ff;
      crc_low_in   = crc_low_ff;
      crc_in       = crc_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      unique case (ctrl_ff)
         ccfr_pkg::CT_IDLE: begin
            if (req_xfer) begin
               unique case (phase_ff)
                  ccfr_pkg::PH_SYNC2: begin
                     phase_in = (rx == sync_second_ff) ? ccfr_pkg::PH_LEN :
                                                         ccfr_pkg::PH_SYNC1;
                  end
                  ccfr_pkg::PH_LEN: begin
                     if ({1'b0, rx} > 9'(MAX_PAYLOAD)) begin
                        phase_in = ccfr_pkg::PH_SYNC1;
                     end else begin
                        frame_len_in = LW'(rx);
                        crc_in       = {rx, 8'h00};
                        bit_cnt_in   = 3'd0;
                        ctrl_in      = ccfr_pkg::CT_CRC;
                        phase_in     = ccfr_pkg::PH_ID;
                     end
                  end
                  ccfr_pkg::PH_ID: begin
                     frame_id_in = rx;
                     fill_in     = '0;
                     crc_in      = crc_ff ^ {rx, 8'h00};
                     bit_cnt_in  = 3'd0;
                     ctrl_in     = ccfr_pkg::CT_CRC;
                     phase_in    = (frame_len_ff == '0) ? ccfr_pkg::PH_CRC_LO :
                                                          ccfr_pkg::PH_PAYLOAD;
                  end
                  ccfr_pkg::PH_PAYLOAD: begin
                     mem_we     = (9'(fill_ff) < 9'(MAX_PAYLOAD));
                     fill_in    = fill_next;
                     crc_in     = crc_ff ^ {rx, 8'h00};
                     bit_cnt_in = 3'd0;
                     ctrl_in    = ccfr_pkg::CT_CRC;
                     if (fill_next >= frame_len_ff) begin
                        phase_in = ccfr_pkg::PH_CRC_LO;
                     end
                  end
                  ccfr_pkg::PH_CRC_LO: begin
                     crc_low_in = rx;
                     phase_in   = ccfr_pkg::PH_CRC_HI;
                  end
                  ccfr_pkg::PH_CRC_HI: begin
                     if (frame_ok && (frame_len_ff != '0)) begin
                        idx_in  = '0;
                        ctrl_in = ccfr_pkg::CT_RD;
                     end
                     phase_in = ccfr_pkg::PH_SYNC1;
                  end
                  default: begin
                     phase_in = (rx == sync_first_ff) ? ccfr_pkg::PH_SYNC2 :
                                                        ccfr_pkg::PH_SYNC1;
                  end
               endcase
            end
         end
         ccfr_pkg::CT_CRC: begin
            crc_in     = crc_shift;
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               ctrl_in = ccfr_pkg::CT_IDLE;
            end
         end
         ccfr_pkg::CT_RD: begin
            ctrl_in = ccfr_pkg::CT_OUT;
         end
         ccfr_pkg::CT_OUT: begin
            if (rsp_xfer) begin
               if ((6'(idx_ff) + 6'd1) == emit_cnt) begin
                  ctrl_in = ccfr_pkg::CT_IDLE;
               end else begin
                  idx_in  = idx_ff + 5'd1;
                  ctrl_in = ccfr_pkg::CT_RD;
               end
            end
         end
         default: begin
            ctrl_in = ccfr_pkg::CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= ccfr_pkg::PH_SYNC1;
         ctrl_ff          <= ccfr_pkg::CT_IDLE;
         sync_first_ff    <= ccfr_pkg::SYNC_FIRST_RST;
         sync_second_ff   <= ccfr_pkg::SYNC_SECOND_RST;
         accept_id_ff     <= ccfr_pkg::ACCEPT_ID_RST;
         accept_length_ff <= ccfr_pkg::ACCEPT_LENGTH_RST;
      end else begin
         phase_ff <= phase_in;
         ctrl_ff  <= ctrl_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               ccfr_pkg::CSR_SYNC_FIRST:    sync_first_ff    <= csr_chan.wdata;
               ccfr_pkg::CSR_SYNC_SECOND:   sync_second_ff   <= csr_chan.wdata;
               ccfr_pkg::CSR_ACCEPT_ID:     accept_id_ff     <= csr_chan.wdata;
               ccfr_pkg::CSR_ACCEPT_LENGTH: accept_length_ff <= csr_chan.wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_len_ff <= frame_len_in;
      frame_id_ff  <= frame_id_in;
      fill_ff      <= fill_in;
      crc_low_ff   <= crc_low_in;
      crc_ff       <= crc_in;
      bit_cnt_ff   <= bit_cnt_in;
      idx_ff       <= idx_in;
   end

   // Payload store: one write port from the parser, one registered read port for replay.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[AW'(fill_ff)] <= rx;
      end
      if (ctrl_ff == ccfr_pkg::CT_RD) begin
         rd_data_ff <= payload_mem[AW'(idx_ff)];
      end
   end

   `CCFR_ASSERT_IMPL(crc_busy_in_frame, ctrl_ff == ccfr_pkg::CT_CRC, phase_ff == ccfr_pkg::PH_ID || phase_ff == ccfr_pkg::PH_PAYLOAD || phase_ff == ccfr_pkg::PH_CRC_LO)
   `CCFR_ASSERT_IMPL(fill_below_length, phase_ff == ccfr_pkg::PH_PAYLOAD, fill_ff < frame_len_ff)
   `CCFR_ASSERT_NEXT(last_ends_replay, rsp_xfer && rsp_chan.last, ctrl_ff == ccfr_pkg::CT_IDLE)
   `CCFR_ASSERT_NEXT(index_steps, rsp_xfer && (ctrl_in == ccfr_pkg::CT_RD), idx_ff == $past(idx_ff) + 5'd1)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the CRC-checked frame receiver core.

typedef struct {
   logic [7:0] data;
   logic [4:0] index;
   logic       last;
} payload_beat_type;

// Tracks the parser the way the block should see it and keeps the payload
// bytes that accepted frames are due to replay.
class frame_scoreboard;
   logic [7:0]          sync_first;
   logic [7:0]          sync_second;
   logic [7:0]          accept_id;
   logic [5:0]          accept_length;
   ccfr_pkg::phase_type phase;
   logic [5:0]          frame_length;
   logic [7:0]          frame_id;
   logic [5:0]          fill_index;
   logic [7:0]          crc_low;
   logic [15:0]         crc_acc;
   logic [7:0]          payload_mem [32];
   payload_beat_type    pending [$];
   int                  failures;
   int                  beats_checked;

   function new();
      sync_first    = ccfr_pkg::SYNC_FIRST_RST;
      sync_second   = ccfr_pkg::SYNC_SECOND_RST;
      accept_id     = ccfr_pkg::ACCEPT_ID_RST;
      accept_length = ccfr_pkg::ACCEPT_LENGTH_RST;
      phase         = ccfr_pkg::PH_SYNC1;
      frame_length  = '0;
      frame_id      = '0;
      fill_index    = '0;
      crc_low       = '0;
      crc_acc       = '0;
      failures      = 0;
      beats_checked = 0;
   endfunction

   static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {value, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = (c << 1) ^ ccfr_pkg::CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   function void write_register(logic [1:0] reg_index, logic [7:0] value);
      case (reg_index)
         ccfr_pkg::CSR_SYNC_FIRST: begin
            sync_first = value;
         end
         ccfr_pkg::CSR_SYNC_SECOND: begin
            sync_second = value;
         end
         ccfr_pkg::CSR_ACCEPT_ID: begin
            accept_id = value;
         end
         ccfr_pkg::CSR_ACCEPT_LENGTH: begin
            accept_length = value[5:0];
         end
         default: begin
         end
      endcase
   endfunction

   function void note_byte(logic [7:0] value);
      logic [15:0]      received;
      payload_beat_type beat;
      case (phase)
         ccfr_pkg::PH_SYNC2: begin
            if (value == sync_second) begin
               phase = ccfr_pkg::PH_LEN;
            end else begin
               phase = ccfr_pkg::PH_SYNC1;
            end
         end
         ccfr_pkg::PH_LEN: begin
            if (value > ccfr_pkg::MAX_RESULTS) begin
               phase = ccfr_pkg::PH_SYNC1;
            end else begin
               frame_length = value[5:0];
               crc_acc      = crc16_step(16'h0000, value);
               phase        = ccfr_pkg::PH_ID;
            end
         end
         ccfr_pkg::PH_ID: begin
            frame_id   = value;
            fill_index = '0;
            crc_acc    = crc16_step(crc_acc, value);
            if (frame_length == 0) begin
               phase = ccfr_pkg::PH_CRC_LO;
            end else begin
               phase = ccfr_pkg::PH_PAYLOAD;
            end
         end
         ccfr_pkg::PH_PAYLOAD: begin
            if (fill_index < ccfr_pkg::MAX_RESULTS) begin
               payload_mem[fill_index] = value;
               fill_index++;
            end
            crc_acc = crc16_step(crc_acc, value);
            if (fill_index >= frame_length) begin
               phase = ccfr_pkg::PH_CRC_LO;
            end
         end
         ccfr_pkg::PH_CRC_LO: begin
            crc_low = value;
            phase   = ccfr_pkg::PH_CRC_HI;
         end
         ccfr_pkg::PH_CRC_HI: begin
            received = {value, crc_low};
            if (received == crc_acc && frame_id == accept_id &&
                frame_length == accept_length) begin
               for (int i = 0; i < frame_length; i++) begin
                  beat.data  = payload_mem[i];
                  beat.index = i[4:0];
                  beat.last  = (i + 1 == frame_length);
                  pending.push_back(beat);
               end
            end
            phase = ccfr_pkg::PH_SYNC1;
         end
         default: begin
            if (value == sync_first) begin
               phase = ccfr_pkg::PH_SYNC2;
            end else begin
               phase = ccfr_pkg::PH_SYNC1;
            end
         end
      endcase
   endfunction

   function void check_beat(logic [7:0] data, logic [4:0] index, logic last);
      payload_beat_type want;
      beats_checked++;
      if (pending.size() == 0) begin
         failures++;
         $display("%0t: payload transfer with none expected: data %h index %0d last %b",
                  $time, data, index, last);
         return;
      end
      want = pending.pop_front();
      if (data !== want.data) begin
         failures++;
         $display("%0t: data_byte expected %h, got %h", $time, want.data, data);
      end
      if (index !== want.index) begin
         failures++;
         $display("%0t: byte_index expected %0d, got %0d", $time, want.index, index);
      end
      if (last !== want.last) begin
         failures++;
         $display("%0t: last expected %b, got %b", $time, want.last, last);
      end
   endfunction

   function void close_out();
      if (pending.size() != 0) begin
         failures++;
         $display("%0t: %0d payload transfers missing, first expected data %h index %0d",
                  $time, pending.size(), pending[0].data, pending[0].index);
      end
   endfunction
endclass

module testbench;

   typedef enum int {
      FK_GOOD,
      FK_BAD_CRC,
      FK_BAD_ID,
      FK_BAD_LEN,
      FK_OVERSIZE,
      FK_BAD_SYNC,
      FK_NOISE
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   ccfr_req_if req_bus ();
   ccfr_rsp_if rsp_bus ();
   ccfr_csr_if csr_bus ();

   crc_checked_frame_receiver_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   frame_scoreboard sb = new();

   int         gap_pct;
   int         stall_pct;
   int         hold_left;
   int         bytes_sent;
   logic [7:0] tx_bytes [$];
   logic [7:0] payload_buf [$];

   // Mostly no gap; when there is one it is usually short and now and then long.
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Payload comes from payload_buf where it was preloaded, else it is random.
   function automatic void push_frame(logic [7:0] len, logic [7:0] id, logic [15:0] crc_xor);
      logic [15:0] crc;
      while (payload_buf.size() < len) begin
         payload_buf.push_back(8'($urandom_range(0, 255)));
      end
      crc = sb.crc16_step(16'h0000, len);
      crc = sb.crc16_step(crc, id);
      tx_bytes.push_back(sb.sync_first);
      tx_bytes.push_back(sb.sync_second);
      tx_bytes.push_back(len);
      tx_bytes.push_back(id);
      for (int i = 0; i < len; i++) begin
         crc = sb.crc16_step(crc, payload_buf[i]);
         tx_bytes.push_back(payload_buf[i]);
      end
      crc = crc ^ crc_xor;
      tx_bytes.push_back(crc[7:0]);
      tx_bytes.push_back(crc[15:8]);
      payload_buf.delete();
   endfunction

   function automatic logic [7:0] good_length();
      if (sb.accept_length <= ccfr_pkg::MAX_RESULTS) begin
         return {2'b00, sb.accept_length};
      end
      return 8'($urandom_range(0, 8));
   endfunction

   function automatic frame_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return FK_GOOD;
      if (roll < 65) return FK_BAD_CRC;
      if (roll < 73) return FK_BAD_ID;
      if (roll < 81) return FK_BAD_LEN;
      if (roll < 87) return FK_OVERSIZE;
      if (roll < 95) return FK_BAD_SYNC;
      return FK_NOISE;
   endfunction

   function automatic void push_random_traffic();
      logic [7:0] len;
      logic [7:0] wrong;
      len = good_length();
      case (pick_kind())
         FK_GOOD: begin
            push_frame(len, sb.accept_id, 16'h0000);
         end
         FK_BAD_CRC: begin
            push_frame(len, sb.accept_id, 16'($urandom_range(1, 65535)));
         end
         FK_BAD_ID: begin
            push_frame(len, sb.accept_id ^ 8'($urandom_range(1, 255)), 16'h0000);
         end
         FK_BAD_LEN: begin
            do begin
               len = 8'($urandom_range(0, 32));
            end while (len == sb.accept_length);
            push_frame(len, sb.accept_id, 16'h0000);
         end
         FK_OVERSIZE: begin
            // The dropped header must not swallow the frame that follows it.
            tx_bytes.push_back(sb.sync_first);
            tx_bytes.push_back(sb.sync_second);
            tx_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'hFF
                                                           : 8'($urandom_range(33, 255)));
            push_frame(len, sb.accept_id, 16'h0000);
         end
         FK_BAD_SYNC: begin
            // A wrong second sync that equals the first sync byte must not restart
            // the frame by itself.
            wrong = (sb.sync_first != sb.sync_second) ? sb.sync_first : ~sb.sync_second;
            tx_bytes.push_back(sb.sync_first);
            tx_bytes.push_back(wrong);
            push_frame(len, sb.accept_id, 16'h0000);
         end
         default: begin
            repeat ($urandom_range(1, 5)) tx_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic send_byte(logic [7:0] value);
      int gap;
      gap = pick_gap(gap_pct);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(value);
      bytes_sent++;
   endtask

   task automatic send_all();
      while (tx_bytes.size() != 0) begin
         send_byte(tx_bytes.pop_front());
      end
   endtask

   // Waits for every expected transfer, then lets the last byte's CRC pass finish.
   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [ccfr_pkg::CSR_W-1:0] reg_index, logic [7:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(reg_index, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [7:0] sf, logic [7:0] ss, logic [7:0] id,
                            logic [7:0] len_word, int budget, int gaps, int stalls);
      int start;
      wait_idle();
      write_reg(ccfr_pkg::CSR_SYNC_FIRST, sf);
      write_reg(ccfr_pkg::CSR_SYNC_SECOND, ss);
      write_reg(ccfr_pkg::CSR_ACCEPT_ID, id);
      write_reg(ccfr_pkg::CSR_ACCEPT_LENGTH, len_word);
      gap_pct   = gaps;
      stall_pct = stalls;
      start     = bytes_sent;
      while (bytes_sent - start < budget) begin
         push_random_traffic();
         send_all();
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         hold_left = pick_gap(stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_beat(rsp_bus.data_byte, rsp_bus.byte_index, rsp_bus.last);
      end
   end

   initial begin
      int phases;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.wdata   = '0;
      gap_pct         = 0;
      stall_pct       = 0;
      bytes_sent      = 0;
      phases          = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: one accepted frame with extreme payload bytes, a wrong
      // second sync equal to the first, and two oversized lengths.
      payload_buf = {8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
      push_frame(8'd6, ccfr_pkg::ACCEPT_ID_RST, 16'h0000);
      tx_bytes.push_back(ccfr_pkg::SYNC_FIRST_RST);
      tx_bytes.push_back(ccfr_pkg::SYNC_FIRST_RST);
      tx_bytes.push_back(ccfr_pkg::SYNC_FIRST_RST);
      tx_bytes.push_back(ccfr_pkg::SYNC_SECOND_RST);
      tx_bytes.push_back(8'd33);
      tx_bytes.push_back(ccfr_pkg::SYNC_FIRST_RST);
      tx_bytes.push_back(ccfr_pkg::SYNC_SECOND_RST);
      tx_bytes.push_back(8'hFF);
      send_all();

      // Extreme settings; the upper bits of the length word must be dropped.
      run_phase(8'h00, 8'hFF, 8'hFF, 8'h60, 80, 20, 20);
      run_phase(8'hFF, 8'h00, 8'h00, 8'h01, 40, 0, 0);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'hC0, 30, 40, 40);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'hFF, 30, 15, 15);

      while (bytes_sent < 300 && phases < 30) begin
         run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)),
                   {2'($urandom_range(0, 3)), 6'($urandom_range(1, 8))}, 50,
                   ($urandom_range(0, 2) == 0) ? 0 : 30,
                   ($urandom_range(0, 2) == 0) ? 0 : 30);
         phases++;
      end

      wait_idle();
      sb.close_out();
      if (sb.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end
endmodule
